[sv/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/tse_pkg.sv]
// types, constants and codes of the table search engine
// no dependencies
package tse_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int VALUE_W     = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = CNT_W'(300);

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_SEARCH   = 1'b1;
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  localparam logic SEARCH_MODE_RST = MODE_BINARY;

  // register index, taken from paddr[2]
  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_SEARCH_MODE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } tse_state_t;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic rd;
    logic step;
    logic load_out;
  } tse_cmd_t;

  typedef struct packed {
    logic more;
  } tse_stat_t;

endpackage

[sv/tse_if.sv]
// request and result channel interfaces of the table search engine
// depends on tse_pkg
interface tse_in_if import tse_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [ADDR_W-1:0]         load_index;
  logic signed [VALUE_W-1:0] load_value;
  logic signed [VALUE_W-1:0] search_key;

  modport source (output valid, op, load_index, load_value, search_key, input ready);
  modport sink (input valid, op, load_index, load_value, search_key, output ready);
endinterface

interface tse_out_if import tse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_index;
  logic [CNT_W-1:0]  probe_count;

  modport source (output valid, found, match_index, probe_count, input ready);
  modport sink (input valid, found, match_index, probe_count, output ready);
endinterface

[sv/tse_ctrl.sv]
// controller state machine of the table search engine
// depends on tse_pkg
module tse_ctrl import tse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  tse_stat_t stat,
  output tse_cmd_t  cmd
);

  tse_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_op == OP_SEARCH) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = stat.more ? ST_CMP : ST_DONE;
      end
      ST_CMP: begin
        state_nxt = ST_READ;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_wr = in_valid && in_op == OP_LOAD;
        cmd.start   = in_valid && in_op == OP_SEARCH;
      end
      ST_READ: begin
        cmd.rd = stat.more;
      end
      ST_CMP: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

[sv/tse_dp.sv]
// datapath of the table search engine: entry memory, search bounds, result register
// depends on tse_pkg
module tse_dp import tse_pkg::*; (
  input  logic                      clk,
  input  tse_cmd_t                  cmd,
  output tse_stat_t                 stat,
  input  logic [ADDR_W-1:0]         load_index,
  input  logic signed [VALUE_W-1:0] load_value,
  input  logic signed [VALUE_W-1:0] search_key,
  input  logic [CNT_W-1:0]          entry_count,
  input  logic                      search_mode,
  output logic                      found,
  output logic [ADDR_W-1:0]         match_index,
  output logic [CNT_W-1:0]          probe_count
);

  localparam int SUM_W = CNT_W + 1;

  logic signed [VALUE_W-1:0] entry_mem_r [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic signed [VALUE_W-1:0] key_r;
  logic [CNT_W-1:0]          lo_r, hie_r, lin_idx_r, probes_r;
  logic [CNT_W-1:0]          lo_nxt, hie_nxt, lin_idx_nxt, probes_nxt;
  logic                      found_r, found_nxt;
  logic [ADDR_W-1:0]         hit_r, hit_nxt;
  logic                      res_found_r;
  logic [ADDR_W-1:0]         res_index_r;
  logic [CNT_W-1:0]          res_probes_r;

  logic [CNT_W-1:0]  n_lim;
  logic [SUM_W-1:0]  mid_sum;
  logic [ADDR_W-1:0] mid;
  logic [ADDR_W-1:0] probe_addr;
  logic              key_eq, key_gt;

  assign n_lim = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count;

  // floor of (lo + hi) / 2 with hi = hie - 1
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hie_r} - SUM_W'(1);
  assign mid        = mid_sum[ADDR_W:1];
  assign probe_addr = (search_mode == MODE_BINARY) ? mid : lin_idx_r[ADDR_W-1:0];

  assign key_eq = key_r == rd_data_r;
  assign key_gt = key_r > rd_data_r;

  always_comb begin
    if (found_r) stat.more = 1'b0;
    else if (search_mode == MODE_BINARY) stat.more = lo_r < hie_r;
    else stat.more = lin_idx_r < n_lim;
  end

  always_comb begin
    lo_nxt      = lo_r;
    hie_nxt     = hie_r;
    lin_idx_nxt = lin_idx_r;
    probes_nxt  = probes_r;
    found_nxt   = found_r;
    hit_nxt     = hit_r;
    if (cmd.start) begin
      lo_nxt      = '0;
      hie_nxt     = n_lim;
      lin_idx_nxt = '0;
      probes_nxt  = '0;
      found_nxt   = 1'b0;
      hit_nxt     = '0;
    end else if (cmd.step) begin
      probes_nxt = probes_r + CNT_W'(1);
      if (key_eq) begin
        found_nxt = 1'b1;
        hit_nxt   = probe_addr;
      end else if (search_mode == MODE_LINEAR) begin
        lin_idx_nxt = lin_idx_r + CNT_W'(1);
      end else if (key_gt) begin
        lo_nxt = CNT_W'(mid) + CNT_W'(1);
      end else begin
        hie_nxt = CNT_W'(mid);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) entry_mem_r[load_index] <= load_value;
    if (cmd.rd) rd_data_r <= entry_mem_r[probe_addr];
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hie_r     <= hie_nxt;
    lin_idx_r <= lin_idx_nxt;
    probes_r  <= probes_nxt;
    found_r   <= found_nxt;
    hit_r     <= hit_nxt;
    if (cmd.start) key_r <= search_key;
    if (cmd.load_out) begin
      res_found_r  <= found_r;
      res_index_r  <= hit_r;
      res_probes_r <= probes_r;
    end
  end

  assign found       = res_found_r;
  assign match_index = res_index_r;
  assign probe_count = res_probes_r;

endmodule

[sv/table_search_engine.sv]
// table search engine: a load request is written into the table from the idle state; a search
// request makes p probes (at most 10 in binary mode, up to the smaller of entry_count and
// TABLE_DEPTH in linear mode), each probe being one read of the single-port table plus one
// compare; no new request is taken until the search is done, and a result waiting in the
// output register holds a finished search until the register is free
// reset clears control state, sets entry_count to 300 and search_mode to binary; table undefined
module table_search_engine import tse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  tse_in_if.sink             in_ch,
  tse_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic             search_mode_r, search_mode_nxt;
  logic             cfg_wr;
  logic             reg_sel;
  tse_cmd_t         cmd;
  tse_stat_t        stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    entry_count_nxt = entry_count_r;
    search_mode_nxt = search_mode_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_ENTRY_COUNT: entry_count_nxt = pwdata[CNT_W-1:0];
        REG_SEARCH_MODE: search_mode_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RST;
      search_mode_r <= SEARCH_MODE_RST;
    end else begin
      entry_count_r <= entry_count_nxt;
      search_mode_r <= search_mode_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ENTRY_COUNT: prdata = PDATA_W'(entry_count_r);
      REG_SEARCH_MODE: prdata = PDATA_W'(search_mode_r);
      default: prdata = '0;
    endcase
  end

  tse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tse_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .load_index  (in_ch.load_index),
    .load_value  (in_ch.load_value),
    .search_key  (in_ch.search_key),
    .entry_count (entry_count_r),
    .search_mode (search_mode_r),
    .found       (out_ch.found),
    .match_index (out_ch.match_index),
    .probe_count (out_ch.probe_count)
  );

endmodule

[sv/tse_checker.sv]
// port-level checks of the table search engine result channel, bound to the top level
// depends on tse_pkg and assert_macros.svh
`include "assert_macros.svh"

module tse_checker import tse_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              found,
  input logic [ADDR_W-1:0] match_index,
  input logic [CNT_W-1:0]  probe_count
);

  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped before taken")
  `ASSERT_RST(a_miss_index, clk, rst_n, out_valid && !found |-> match_index == '0, "miss with nonzero index")
  `ASSERT_RST(a_hit_probes, clk, rst_n, out_valid && found |-> probe_count != '0, "hit without a probe")
  `ASSERT_RST(a_probe_max, clk, rst_n, out_valid |-> probe_count <= CNT_W'(TABLE_DEPTH), "probe count too large")
  `ASSERT_ALL(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind table_search_engine tse_checker u_tse_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.found),
  .match_index (out_ch.match_index),
  .probe_count (out_ch.probe_count)
);

[test/tb.sv]
`timescale 1ns / 100ps
// testbench of table_search_engine: loads tables, searches them linearly and by halving,
// and checks each result against a predictor kept in the bench
// depends on tse_pkg, the channel interfaces in tse_if.sv and the engine itself
module tb;
  import tse_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic               op;
    logic [ADDR_W-1:0]  load_index;
    logic [VALUE_W-1:0] load_value;
    logic [VALUE_W-1:0] search_key;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_index;
    logic [CNT_W-1:0]  probe_count;
  } search_result_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tse_in_if  in_ch ();
  tse_out_if out_ch ();

  table_search_engine dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  request_t           req_queue[$];
  search_result_t     expected_results[$];
  logic [VALUE_W-1:0] model_tbl [TABLE_DEPTH];
  logic [VALUE_W-1:0] gen_tbl [TABLE_DEPTH];
  logic [CNT_W-1:0]   model_count;
  logic               model_mode;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 mismatch_count;
  int                 stall_cycles;
  logic               in_taken;
  request_t           drive_req;
  search_result_t     seen;
  search_result_t     want;

  function automatic int active_entries();
    return (model_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_count);
  endfunction

  function automatic search_result_t predict_search(logic [VALUE_W-1:0] key_bits);
    search_result_t             r;
    logic signed [VALUE_W-1:0] key;
    logic signed [VALUE_W-1:0] entry;
    int                         n;
    int                         lo;
    int                         hi;
    int                         mid;
    int                         probes;
    r = '0;
    key = key_bits;
    probes = 0;
    n = active_entries();
    if (model_mode == MODE_LINEAR) begin
      for (int i = 0; i < n && !r.found; i++) begin
        probes++;
        entry = model_tbl[i];
        if (entry == key) begin
          r.found = 1'b1;
          r.match_index = ADDR_W'(i);
        end
      end
    end else begin
      lo = 0;
      hi = n - 1;
      while (!r.found && hi >= lo) begin
        mid = (lo + hi) / 2;
        entry = model_tbl[mid];
        probes++;
        if (key == entry) begin
          r.found = 1'b1;
          r.match_index = ADDR_W'(mid);
        end else if (key > entry) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    r.probe_count = CNT_W'(probes);
    return r;
  endfunction

  function automatic void add_load(int idx, logic [VALUE_W-1:0] val);
    request_t r;
    r.op = OP_LOAD;
    r.load_index = ADDR_W'(idx);
    r.load_value = val;
    r.search_key = $urandom();
    req_queue.push_back(r);
    gen_tbl[idx] = val;
  endfunction

  function automatic void add_search(logic [VALUE_W-1:0] key);
    request_t r;
    r.op = OP_SEARCH;
    r.load_index = ADDR_W'($urandom());
    r.load_value = $urandom();
    r.search_key = key;
    req_queue.push_back(r);
  endfunction

  // ascending table in entries 0..n-1, sometimes clustered so values repeat
  function automatic void fill_sorted(int n);
    logic [VALUE_W-1:0] vals [TABLE_DEPTH];
    longint             v;
    longint             span;
    span = 64'h1_0000_0000 / n;
    if (span > 64'h0_FFFF_FFFF) span = 64'h0_FFFF_FFFF;
    v = -64'sd2147483648 + longint'($urandom_range(0, 32'(span)));
    if ($urandom_range(3) == 0) begin
      span = 3;
      v = longint'($signed($urandom()));
    end
    for (int i = 0; i < n; i++) begin
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      vals[i] = v[VALUE_W-1:0];
      v = v + longint'($urandom_range(0, 32'(span)));
    end
    if ($urandom_range(3) == 0) begin
      vals[0] = VAL_MIN;
      vals[n-1] = VAL_MAX;
    end
    if ($urandom_range(1)) begin
      for (int i = 0; i < n; i++) add_load(i, vals[i]);
    end else begin
      for (int i = n - 1; i >= 0; i--) add_load(i, vals[i]);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] pick_key();
    int                 n;
    int                 sel;
    logic [VALUE_W-1:0] k;
    n = active_entries();
    sel = $urandom_range(99);
    if (n == 0 || sel >= 75) return $urandom();
    k = gen_tbl[$urandom_range(0, n - 1)];
    if (sel < 50) return k;
    if (sel < 65) return $urandom_range(1) ? k + 1'b1 : k - 1'b1;
    case ($urandom_range(3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // searches mixed with loads that may break the order or copy entries
  function automatic void random_phase(int n_items, int noise_pct);
    int n;
    int idx;
    n = active_entries();
    repeat (n_items) begin
      if ($urandom_range(99) < noise_pct) begin
        idx = (n != 0 && $urandom_range(1)) ? $urandom_range(0, n - 1)
                                            : $urandom_range(0, TABLE_DEPTH - 1);
        if (n != 0 && $urandom_range(1)) add_load(idx, gen_tbl[$urandom_range(0, n - 1)]);
        else add_load(idx, $urandom());
      end else begin
        add_search(pick_key());
      end
    end
  endfunction

  task automatic wait_drained();
    while (req_queue.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(int count, logic mode);
    settle();
    apb_write(REG_ENTRY_COUNT, PDATA_W'(count));
    apb_write(REG_SEARCH_MODE, PDATA_W'(mode));
    model_count = CNT_W'(count);
    model_mode = mode;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = req_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= drive_req.op;
        in_ch.load_index <= drive_req.load_index;
        in_ch.load_value <= drive_req.load_value;
        in_ch.search_key <= drive_req.search_key;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor, predictor update and stall watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        seen.found = out_ch.found;
        seen.match_index = out_ch.match_index;
        seen.probe_count = out_ch.probe_count;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: found=%0b index=%0d probes=%0d",
                     seen.found, seen.match_index, seen.probe_count);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected found=%0b index=%0d probes=%0d, got found=%0b index=%0d probes=%0d",
                       want.found, want.match_index, want.probe_count,
                       seen.found, seen.match_index, seen.probe_count);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_LOAD) model_tbl[in_ch.load_index] = in_ch.load_value;
        else expected_results.push_back(predict_search(in_ch.search_key));
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [VALUE_W-1:0] dir_vals [8];
    int                 n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.load_index = '0;
    in_ch.load_value = '0;
    in_ch.search_key = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    stall_cycles = 0;
    model_count = ENTRY_COUNT_RST;
    model_mode = SEARCH_MODE_RST;
    send_idle_pct = 12;
    recv_idle_pct = 88;
    dir_vals = '{VAL_MIN, -1000, -1, 0, 1, 1000, 32'h4000_0000, VAL_MAX};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single entry, zero count, small sorted table
    set_config(1, MODE_LINEAR);
    add_load(0, VAL_MIN);
    add_search(VAL_MIN);
    add_search(VAL_MAX);
    add_search('0);
    set_config(1, MODE_BINARY);
    add_search(VAL_MIN);
    add_search('1);
    set_config(0, MODE_LINEAR);
    add_search(5);
    set_config(0, MODE_BINARY);
    add_search(VAL_MAX);
    set_config(8, MODE_BINARY);
    for (int i = 1; i < 8; i++) add_load(i, dir_vals[i]);
    add_search(VAL_MIN);
    add_search(VAL_MAX);
    add_search('0);
    add_search('1);
    add_search(999);
    add_search(1);
    set_config(8, MODE_LINEAR);
    add_search(VAL_MAX);
    add_search(999);

    // full sorted table
    set_config(TABLE_DEPTH, MODE_BINARY);
    fill_sorted(TABLE_DEPTH);
    random_phase(200, 0);

    // count beyond the table, full linear scans, short linear tables
    set_config(1023, MODE_BINARY);
    send_idle_pct = 88;
    recv_idle_pct = 12;
    random_phase(120, 20);
    set_config(TABLE_DEPTH, MODE_LINEAR);
    random_phase(10, 0);
    repeat (4) begin
      set_config($urandom_range(1, 48), MODE_LINEAR);
      random_phase(60, 25);
    end

    // freshly sorted short tables, no idling
    for (int p = 0; p < 5; p++) begin
      n = $urandom_range(1, 64);
      set_config(n, MODE_BINARY);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_sorted(n);
      random_phase(30, 10);
      if (p == 0) wait_drained();
      random_phase(30, 10);
    end
    set_config(300, MODE_BINARY);
    random_phase(150, 10);
    set_config(2, MODE_LINEAR);
    random_phase(40, 20);

    settle();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
